FILE: rtl/sus_pkg.sv
// Shared types and codes for the sorted unique stack insert unit.
// Depends on nothing; every other file in rtl imports it.
`timescale 1ns / 1ps
`default_nettype none

package sus_pkg;

    localparam int unsigned ValueW = 32;
    localparam int unsigned OccW   = 5;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic                     command;
        logic signed [ValueW-1:0] value;
    } request_t;

    typedef struct packed {
        logic                     accepted;
        logic [1:0]               status;
        logic signed [ValueW-1:0] popped_value;
        logic [OccW-1:0]          occupancy;
    } result_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                     write_en;
        logic signed [ValueW-1:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_unique_stack_insert_unit.sv
// Sorted unique stack: a chain of sus_cell instances plus the fill count.
// A result appears with done in the cycle after start is taken.
// Throughput: one command per cycle; every cell compares and shifts at once,
// so busy stays low. The receiver cannot stall results.
// Reset empties the store by clearing the fill count; cell contents need no
// clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_stack_insert_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sus_pkg::request_t request,
    output logic               done,
    output sus_pkg::result_t   result
);
    import sus_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     done_reg;
    logic                     done_next;
    result_t                  result_reg;
    result_t                  result_next;

    cell_ctl_t                ctl;
    logic [DEPTH-1:0]         occ;
    logic [DEPTH-1:0]         less;
    logic signed [ValueW-1:0] entries [DEPTH];
    logic [DEPTH:0]           dup_chain;
    logic [ValueW-1:0]        pop_chain [DEPTH+1];

    logic                     is_dup;
    logic                     is_full;
    logic                     is_empty;
    logic                     do_insert;
    logic [31:0]              count_ext;

    assign dup_chain[0] = 1'b0;
    assign pop_chain[0] = '0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                     left_less;
            logic signed [ValueW-1:0] left_entry;
            logic                     above_occ;

            if (i == 0)
            begin : g_first
                assign left_less  = 1'b1;
                assign left_entry = '0;
            end
            else
            begin : g_rest
                assign left_less  = less[i-1];
                assign left_entry = entries[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_top
                assign above_occ = 1'b0;
            end
            else
            begin : g_mid
                assign above_occ = occ[i+1];
            end

            sus_cell #(
                .CW    (CW),
                .INDEX (i)
            ) u_cell (
                .clk            (clk),
                .ctl            (ctl),
                .count          (count_reg),
                .left_less      (left_less),
                .left_entry     (left_entry),
                .above_occupied (above_occ),
                .dup_in         (dup_chain[i]),
                .pop_in         (pop_chain[i]),
                .occupied       (occ[i]),
                .less           (less[i]),
                .entry          (entries[i]),
                .dup_out        (dup_chain[i+1]),
                .pop_out        (pop_chain[i+1])
            );
        end
    endgenerate

    assign is_dup    = dup_chain[DEPTH];
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign do_insert = start && (request.command == CMD_INSERT) && !is_dup && !is_full;

    assign ctl.write_en = do_insert;
    assign ctl.value    = request.value;

    always_comb
    begin
        count_next               = count_reg;
        done_next                = start;
        result_next              = result_reg;
        if (start)
        begin
            result_next.accepted     = 1'b0;
            result_next.popped_value = '0;
            result_next.status       = ST_OK;
            if (request.command == CMD_INSERT)
            begin
                if (is_dup)
                begin
                    result_next.status = ST_DUP;
                end
                else if (is_full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    result_next.accepted = 1'b1;
                    count_next           = count_reg + CW'(1);
                end
            end
            else if (is_empty)
            begin
                result_next.status = ST_EMPTY;
            end
            else
            begin
                result_next.accepted     = 1'b1;
                result_next.popped_value = pop_chain[DEPTH];
                count_next               = count_reg - CW'(1);
            end
        end
        count_ext                 = 32'(count_next);
        result_next.occupancy     = count_ext[OccW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/sus_cell.sv
// One storage cell of the sorted chain: holds one entry and compares it with
// the broadcast value. Depends on sus_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sus_cell #(
    parameter int unsigned CW    = 5,
    parameter int unsigned INDEX = 0
) (
    input  wire logic                             clk,
    input  wire sus_pkg::cell_ctl_t               ctl,
    input  wire logic [CW-1:0]                    count,
    input  wire logic                             left_less,
    input  wire logic signed [sus_pkg::ValueW-1:0] left_entry,
    input  wire logic                             above_occupied,
    input  wire logic                             dup_in,
    input  wire logic [sus_pkg::ValueW-1:0]       pop_in,
    output logic                                  occupied,
    output logic                                  less,
    output logic signed [sus_pkg::ValueW-1:0]     entry,
    output logic                                  dup_out,
    output logic [sus_pkg::ValueW-1:0]            pop_out
);
    import sus_pkg::*;

    logic signed [ValueW-1:0] entry_reg;
    logic signed [ValueW-1:0] entry_next;

    assign occupied = (count > CW'(INDEX));
    assign less     = occupied && (entry_reg < ctl.value);
    assign entry    = entry_reg;
    assign dup_out  = dup_in | (occupied && (entry_reg == ctl.value));
    // Only the topmost occupied cell contributes to the popped value.
    assign pop_out  = pop_in | ((occupied && !above_occupied) ? entry_reg : '0);

    // A cell below the insert point keeps its entry, the cell at the point takes
    // the new value, and every cell above it takes its lower neighbour's entry.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.write_en && !less)
        begin
            entry_next = left_less ? ctl.value : left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for sorted_unique_stack_insert_unit: directed and random
// insert/pop commands checked against an in-bench sorted-stack predictor.
// Depends on rtl/sus_pkg.sv and rtl/sorted_unique_stack_insert_unit.sv.
`timescale 1ns / 1ps

module tb_top;

    import sus_pkg::*;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned IDLE_LIMIT  = 1000;
    localparam int unsigned RANDOM_CMDS = 1000;

    typedef struct {
        request_t req;
        bit       drain_first;
    } cmd_entry_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    cmd_entry_t cmd_q[$];
    result_t    outcome_q[$];

    // Predictor state: ascending values, index 0 the smallest.
    logic signed [ValueW-1:0] stack_vals [STACK_DEPTH];
    int unsigned              stack_fill = 0;

    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    logic        taken;
    int unsigned burst_left;
    int unsigned gap_left;

    sorted_unique_stack_insert_unit #(
        .DEPTH(STACK_DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic result_t sorted_stack_step(request_t req);
        result_t     res;
        int unsigned pos;
        res = '0;
        res.status = ST_OK;
        if (req.command == CMD_INSERT)
        begin
            pos = 0;
            while (pos < stack_fill && stack_vals[pos] < req.value)
            begin
                pos++;
            end
            // The duplicate check takes precedence over the full check.
            if (pos < stack_fill && stack_vals[pos] == req.value)
            begin
                res.status = ST_DUP;
            end
            else if (stack_fill >= STACK_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                for (int unsigned k = stack_fill; k > pos; k--)
                begin
                    stack_vals[k] = stack_vals[k-1];
                end
                stack_vals[pos] = req.value;
                stack_fill++;
                res.accepted = 1'b1;
            end
        end
        else
        begin
            if (stack_fill == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                stack_fill--;
                res.popped_value = stack_vals[stack_fill];
                res.accepted = 1'b1;
            end
        end
        res.occupancy = stack_fill[OccW-1:0];
        return res;
    endfunction

    function automatic void queue_cmd(logic cmd, logic signed [ValueW-1:0] val,
                                      bit drain_first);
        cmd_entry_t e;
        e.req.command = cmd;
        e.req.value = val;
        e.drain_first = drain_first;
        cmd_q.push_back(e);
    endfunction

    function automatic logic signed [ValueW-1:0] pick_value();
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            // A narrow pool keeps duplicates frequent.
            return $signed(ValueW'($urandom_range(0, 40))) - 20;
        end
        else if (kind < 65)
        begin
            case ($urandom_range(0, 5))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh8000_0001;
                3: return 32'sh7fff_fffe;
                4: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom());
    endfunction

    // Driver: presents transfers at the falling edge, in bursts with gaps.
    always @(negedge clk)
    begin
        cmd_entry_t next_cmd;
        if (rst_n && (!start || taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (cmd_q.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (cmd_q[0].drain_first && outcome_q.size() != 0)
            begin
                start <= 1'b0;
            end
            else
            begin
                next_cmd = cmd_q.pop_front();
                start <= 1'b1;
                request <= next_cmd.req;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Monitor: records accepted commands and checks each result strobe.
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            taken <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            taken <= start && !busy;
            if (start && !busy)
            begin
                outcome_q.push_back(sorted_stack_step(request));
            end
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result: acc=%0b st=%0d pop=%0d occ=%0d",
                                 result.accepted, result.status,
                                 result.popped_value, result.occupancy);
                    end
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (result.accepted !== want.accepted || result.status !== want.status
                        || result.popped_value !== want.popped_value
                        || result.occupancy !== want.occupancy)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: exp acc=%0b st=%0d pop=%0d occ=%0d",
                                     want.accepted, want.status,
                                     want.popped_value, want.occupancy);
                            $display("          got acc=%0b st=%0d pop=%0d occ=%0d",
                                     result.accepted, result.status,
                                     result.popped_value, result.occupancy);
                        end
                    end
                end
            end
            if ((start && !busy) || done)
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("** sorted_unique_stack_insert_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int unsigned ins_pct;
        bit          is_insert;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        burst_left = 1;
        gap_left = 0;
        for (int unsigned i = 0; i < STACK_DEPTH; i++)
        begin
            stack_vals[i] = '0;
        end

        // Directed: empty pop, extremes, duplicates at both ends, fill to full.
        queue_cmd(CMD_POP, 32'sh1234_5678, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh8000_0000, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh0000_0000, 1'b0);
        queue_cmd(CMD_INSERT, -32'sd1, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh8000_0000, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
        queue_cmd(CMD_POP, 32'shffff_ffff, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh5555_5555, 1'b0);
        queue_cmd(CMD_INSERT, 32'shaaaa_aaaa, 1'b0);
        queue_cmd(CMD_INSERT, 32'sd1, 1'b0);
        queue_cmd(CMD_INSERT, 32'sd2, 1'b0);
        queue_cmd(CMD_INSERT, 32'sd100, 1'b0);
        queue_cmd(CMD_INSERT, -32'sd100, 1'b0);
        queue_cmd(CMD_INSERT, 32'sd7, 1'b0);
        queue_cmd(CMD_INSERT, -32'sd7, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh0000_ffff, 1'b0);
        queue_cmd(CMD_INSERT, 32'shffff_0000, 1'b0);
        queue_cmd(CMD_INSERT, 32'sd12345, 1'b0);
        queue_cmd(CMD_INSERT, -32'sd12345, 1'b0);
        queue_cmd(CMD_INSERT, 32'sd99, 1'b0);
        queue_cmd(CMD_INSERT, 32'sd100, 1'b0);
        queue_cmd(CMD_POP, 32'sh0000_0000, 1'b0);

        // Random: phases with a varying insert share so the store swings
        // between empty and full many times.
        ins_pct = 50;
        for (int unsigned n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ins_pct = 25;
                    1: ins_pct = 50;
                    2: ins_pct = 75;
                    default: ins_pct = 90;
                endcase
            end
            is_insert = ($urandom_range(0, 99) < ins_pct);
            queue_cmd(is_insert ? CMD_INSERT : CMD_POP, pick_value(),
                      (n == 0) || (n == RANDOM_CMDS / 2));
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_q.size() != 0 || start)
        begin
            @(posedge clk);
        end
        while (outcome_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);

        if (mismatches == 0 && outcome_q.size() == 0)
        begin
            $display("** sorted_unique_stack_insert_unit: PASSED **");
        end
        else
        begin
            $display("** sorted_unique_stack_insert_unit: FAILED **");
        end
        $finish;
    end

endmodule
